// File: rtl/aptq_pkg.sv
`default_nettype none
package aptq_pkg;

   typedef enum logic [1:0] {
      OP_SUBMIT  = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_DISPATCH = 3'd1,
      ST_EXPIRED  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   localparam logic [1:0] LV_BACKGROUND = 2'd0;
   localparam logic [1:0] LV_NORMAL     = 2'd1;
   localparam logic [1:0] LV_HIGH       = 2'd2;
   localparam logic [1:0] LV_CRITICAL   = 2'd3;

   localparam logic CSR_STARVATION = 1'b0;
   localparam logic CSR_ESCALATION = 1'b1;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_CLEAR,
      FSM_SUB_RD,
      FSM_SUB_WR,
      FSM_DQ_RD,
      FSM_DQ_DATA,
      FSM_BG_RD,
      FSM_BG_CHK,
      FSM_ESC_RD,
      FSM_ESC_CHK,
      FSM_SRV_RD,
      FSM_SRV_DATA,
      FSM_OUT
   } fsm_type;

endpackage
`default_nettype wire

// File: rtl/aging_priority_task_queue.sv
`default_nettype none
// a submit reads the free-list head and then stores the entry, or is rejected when the
// store is full; a dequeue serves the critical head directly when critical is non-empty,
// else it first runs the background and escalation checks, moving aged heads up a level
// one item at a time; the next item is taken only after the result beat has been accepted
// reset: synchronous; a clearing pass over all ENTRIES link words rebuilds the free list
// after reset and after a flush, during which no item is taken
module aging_priority_task_queue #(
   parameter int ENTRIES        = 64,
   parameter int CRITICAL_SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [1:0]  req_priority_req,
   input  wire logic [15:0] req_task_handle,
   input  wire logic [31:0] req_deadline_ms,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_out_handle,
   output logic [1:0]       rsp_served_level,
   output logic             rsp_degraded,
   output logic [6:0]       rsp_depth_background,
   output logic [6:0]       rsp_depth_normal,
   output logic [6:0]       rsp_depth_high,
   output logic [6:0]       rsp_depth_critical,
   output logic [31:0]      rsp_executed_count,
   output logic [31:0]      rsp_bump_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import aptq_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = 16 + 32 + 32;

   // registers
   fsm_type          state_ff, state_in;
   logic [31:0]      guard_ff, guard_in, esc_ff, esc_in;
   logic [AW-1:0]    head_ff [4], head_in [4];
   logic [AW-1:0]    tail_ff [4], tail_in [4];
   logic [CW-1:0]    cnt_ff [4], cnt_in [4];
   logic [AW-1:0]    fhead_ff, fhead_in;
   logic [CW-1:0]    fcnt_ff, fcnt_in;
   logic [31:0]      exec_ff, exec_in, bump_ff, bump_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [1:0]       op_ff, op_in, prio_ff, prio_in, lv_ff, lv_in;
   logic [15:0]      hdl_ff, hdl_in;
   logic [31:0]      dl_ff, dl_in, now_ff, now_in;
   logic             rv_ff, rv_in;
   logic [2:0]       st_ff, st_in;
   logic [15:0]      oh_ff, oh_in;
   logic [1:0]       sl_ff, sl_in;
   logic             dg_ff, dg_in;
   // marks a dequeue that took the critical fast path
   logic             early_ff, early_in;

   // memories
   logic             lk_we, dt_we;
   logic [AW-1:0]    lk_wa, lk_wd, lk_ra, lk_rd, dt_wa, dt_ra;
   logic [DW-1:0]    dt_wd, dt_rd;

   aptq_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd));

   aptq_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data (
      .clock(clock), .wr_en(dt_we), .wr_addr(dt_wa), .wr_data(dt_wd),
      .rd_addr(dt_ra), .rd_data(dt_rd));

   logic [15:0] rd_hdl;
   logic [31:0] rd_time, rd_dl, age;
   assign rd_hdl  = dt_rd[DW-1 -: 16];
   assign rd_time = dt_rd[63:32];
   assign rd_dl   = dt_rd[31:0];
   assign age     = now_ff - rd_time;

   assign req_ready = (state_ff == FSM_IDLE) && !rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_out_handle = oh_ff;
   assign rsp_served_level = sl_ff;
   assign rsp_degraded = dg_ff;
   assign rsp_depth_background = 7'(cnt_ff[0]);
   assign rsp_depth_normal = 7'(cnt_ff[1]);
   assign rsp_depth_high = 7'(cnt_ff[2]);
   assign rsp_depth_critical = 7'(cnt_ff[3]);
   assign rsp_executed_count = exec_ff;
   assign rsp_bump_count = bump_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      guard_in = guard_ff;
      esc_in = esc_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      fhead_in = fhead_ff;
      fcnt_in = fcnt_ff;
      exec_in = exec_ff;
      bump_in = bump_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      prio_in = prio_ff;
      lv_in = lv_ff;
      hdl_in = hdl_ff;
      dl_in = dl_ff;
      now_in = now_ff;
      rv_in = rv_ff;
      st_in = st_ff;
      oh_in = oh_ff;
      sl_in = sl_ff;
      dg_in = dg_ff;
      early_in = early_ff;
      lk_we = 1'b0;
      lk_wa = '0;
      lk_wd = '0;
      lk_ra = '0;
      dt_we = 1'b0;
      dt_wa = fhead_ff;
      dt_wd = {hdl_ff, now_ff, dl_ff};
      dt_ra = '0;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (csr_valid) begin
         if (csr_index == CSR_STARVATION) begin
            guard_in = csr_data;
         end else begin
            esc_in = csr_data;
         end
      end

      case (state_ff)
         FSM_CLEAR: begin
            // rebuild free list one entry a beat
            lk_we = 1'b1;
            lk_wa = clr_ff;
            lk_wd = (32'(clr_ff) == ENTRIES - 1) ? '0 : clr_ff + AW'(1);
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == ENTRIES - 1) begin
               clr_in = '0;
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = req_opcode;
               prio_in = req_priority_req;
               hdl_in = req_task_handle;
               dl_in = req_deadline_ms;
               now_in = req_now_ms;
               oh_in = '0;
               sl_in = '0;
               dg_in = 1'b0;
               early_in = 1'b0;
               st_in = ST_EMPTY;
               case (op_type'(req_opcode))
                  OP_SUBMIT: begin
                     if (fcnt_ff == '0) begin
                        st_in = ST_FULL;
                        state_in = FSM_OUT;
                     end else begin
                        lk_ra = fhead_ff;
                        state_in = FSM_SUB_RD;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (cnt_ff[3] != '0) begin
                        // critical served before aging skips the deadline check
                        lv_in = LV_CRITICAL;
                        early_in = 1'b1;
                        lk_ra = head_ff[3];
                        dt_ra = head_ff[3];
                        state_in = FSM_SRV_RD;
                     end else begin
                        dt_ra = head_ff[0];
                        state_in = FSM_BG_RD;
                     end
                  end
                  OP_FLUSH: begin
                     for (int i = 0; i < 4; i++) begin
                        head_in[i] = '0;
                        tail_in[i] = '0;
                        cnt_in[i] = '0;
                     end
                     fhead_in = '0;
                     fcnt_in = CW'(ENTRIES);
                     st_in = ST_ACCEPTED;
                     rv_in = 1'b1;
                     clr_in = '0;
                     state_in = FSM_CLEAR;
                  end
                  default: begin
                     state_in = FSM_OUT;
                  end
               endcase
            end
         end
         FSM_SUB_RD: begin
            // link of free head lands next beat
            lk_ra = fhead_ff;
            state_in = FSM_SUB_WR;
            if (prio_ff == LV_CRITICAL && 32'(cnt_ff[3]) >= CRITICAL_SLOTS) begin
               prio_in = LV_HIGH;
               dg_in = 1'b1;
            end
         end
         FSM_SUB_WR: begin
            // store payload, relink
            dt_we = 1'b1;
            fhead_in = lk_rd;
            fcnt_in = fcnt_ff - CW'(1);
            if (cnt_ff[prio_ff] == '0) begin
               head_in[prio_ff] = fhead_ff;
            end else begin
               lk_we = 1'b1;
               lk_wa = tail_ff[prio_ff];
               lk_wd = fhead_ff;
            end
            tail_in[prio_ff] = fhead_ff;
            cnt_in[prio_ff] = cnt_ff[prio_ff] + CW'(1);
            st_in = ST_ACCEPTED;
            state_in = FSM_OUT;
         end
         FSM_BG_RD: begin
            // background head data lands next beat
            dt_ra = head_ff[0];
            state_in = FSM_BG_CHK;
         end
         FSM_BG_CHK: begin
            // whole background level joins normal once its head has aged past the guard
            if (guard_ff != '0 && cnt_ff[0] != '0 && age > guard_ff) begin
               if (cnt_ff[1] == '0) begin
                  head_in[1] = head_ff[0];
               end else begin
                  lk_we = 1'b1;
                  lk_wa = tail_ff[1];
                  lk_wd = head_ff[0];
               end
               tail_in[1] = tail_ff[0];
               cnt_in[1] = cnt_ff[1] + cnt_ff[0];
               cnt_in[0] = '0;
               bump_in = bump_ff + 32'd1;
            end
            lv_in = LV_NORMAL;
            state_in = FSM_ESC_RD;
         end
         FSM_ESC_RD: begin
            // read head of normal or high with its link, or pick the level to serve
            if (esc_ff == '0 || lv_ff == LV_CRITICAL || cnt_ff[lv_ff] == '0 ||
                (lv_ff == LV_HIGH && 32'(cnt_ff[3]) >= CRITICAL_SLOTS)) begin
               if (lv_ff == LV_NORMAL) begin
                  lv_in = LV_HIGH;
               end else begin
                  lv_in = LV_CRITICAL;
                  state_in = FSM_SRV_RD;
                  // choose highest non-empty level
                  if (cnt_ff[3] != '0) lv_in = LV_CRITICAL;
                  else if (cnt_ff[2] != '0) lv_in = LV_HIGH;
                  else if (cnt_ff[1] != '0) lv_in = LV_NORMAL;
                  else if (cnt_ff[0] != '0) lv_in = LV_BACKGROUND;
                  else begin
                     st_in = ST_EMPTY;
                     state_in = FSM_OUT;
                  end
                  lk_ra = head_ff[lv_in];
                  dt_ra = head_ff[lv_in];
               end
            end else begin
               lk_ra = head_ff[lv_ff];
               dt_ra = head_ff[lv_ff];
               state_in = FSM_ESC_CHK;
            end
         end
         FSM_ESC_CHK: begin
            if (age > esc_ff) begin
               // move head entry up one level
               head_in[lv_ff] = lk_rd;
               cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
               if (cnt_ff[lv_ff + 2'd1] == '0) begin
                  head_in[lv_ff + 2'd1] = head_ff[lv_ff];
               end else begin
                  lk_we = 1'b1;
                  lk_wa = tail_ff[lv_ff + 2'd1];
                  lk_wd = head_ff[lv_ff];
               end
               tail_in[lv_ff + 2'd1] = head_ff[lv_ff];
               cnt_in[lv_ff + 2'd1] = cnt_ff[lv_ff + 2'd1] + CW'(1);
            end else if (lv_ff == LV_NORMAL) begin
               lv_in = LV_HIGH;
            end else begin
               // done aging; serve selection next
               lv_in = LV_CRITICAL;
            end
            state_in = FSM_ESC_RD;
         end
         FSM_SRV_RD: begin
            // head data and link land next beat
            lk_ra = head_ff[lv_ff];
            dt_ra = head_ff[lv_ff];
            state_in = FSM_SRV_DATA;
         end
         FSM_SRV_DATA: begin
            // pop head, release slot to free list
            head_in[lv_ff] = lk_rd;
            cnt_in[lv_ff] = cnt_ff[lv_ff] - CW'(1);
            lk_we = 1'b1;
            lk_wa = head_ff[lv_ff];
            lk_wd = fhead_ff;
            fhead_in = head_ff[lv_ff];
            fcnt_in = fcnt_ff + CW'(1);
            exec_in = exec_ff + 32'd1;
            oh_in = rd_hdl;
            sl_in = lv_ff;
            st_in = (op_ff == OP_DEQUEUE && !early_ff && rd_dl != '0 && now_ff > rd_dl)
                    ? ST_EXPIRED : ST_DISPATCH;
            state_in = FSM_OUT;
         end
         FSM_OUT: begin
            rv_in = 1'b1;
            dg_in = dg_ff;
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
         guard_ff <= 32'd1000;
         esc_ff <= 32'd5000;
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         fhead_ff <= '0;
         fcnt_ff <= CW'(ENTRIES);
         exec_ff <= '0;
         bump_ff <= '0;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         early_ff <= 1'b0;
         dg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         guard_ff <= guard_in;
         esc_ff <= esc_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
         fhead_ff <= fhead_in;
         fcnt_ff <= fcnt_in;
         exec_ff <= exec_in;
         bump_ff <= bump_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         early_ff <= early_in;
         dg_ff <= dg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      prio_ff <= prio_in;
      lv_ff <= lv_in;
      hdl_ff <= hdl_in;
      dl_ff <= dl_in;
      now_ff <= now_in;
      st_ff <= st_in;
      oh_ff <= oh_in;
      sl_ff <= sl_in;
   end
endmodule
`default_nettype wire

// File: rtl/aptq_ram.sv
`default_nettype none
module aptq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
   import aptq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 64;
   localparam int CRIT_SLOTS = 8;
   localparam int CYCLE_CAP  = 1500000;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] handle;
      logic [1:0]  level;
      logic        degraded;
      logic [6:0]  d_bg;
      logic [6:0]  d_nm;
      logic [6:0]  d_hi;
      logic [6:0]  d_cr;
      logic [31:0] executed;
      logic [31:0] bumps;
   } task_rsp_type;

   // behavioral copy of the task queue and its queue of expected responses
   class task_queue_scoreboard;
      logic [31:0] guard_ms;
      logic [31:0] escal_ms;
      logic [15:0] slot_handle [DEPTH];
      logic [31:0] slot_time   [DEPTH];
      logic [31:0] slot_dl     [DEPTH];
      int          levels [4][$];
      int          free_slots [$];
      logic [31:0] exec_total;
      logic [31:0] bump_total;
      task_rsp_type pending [$];
      int          errors;
      int          checked;
      int          n_expired;
      int          n_degraded;
      int          n_rejected;

      function new();
         guard_ms = 32'd1000;
         escal_ms = 32'd5000;
         exec_total = '0;
         bump_total = '0;
         errors = 0;
         checked = 0;
         n_expired = 0;
         n_degraded = 0;
         n_rejected = 0;
         clear_store();
      endfunction

      function void clear_store();
         for (int l = 0; l < 4; l++) levels[l].delete();
         free_slots.delete();
         for (int i = 0; i < DEPTH; i++) free_slots.push_back(i);
      endfunction

      function bit is_aged(int lv, logic [31:0] now, logic [31:0] lim);
         logic [31:0] age;
         age = now - slot_time[levels[lv][0]];
         return age > lim;
      endfunction

      function void note_request(logic [1:0] op, logic [1:0] prio, logic [15:0] hdl,
                                 logic [31:0] dl, logic [31:0] now);
         task_rsp_type r;
         int idx;
         int lv;
         r = '0;
         r.status = ST_EMPTY;
         if (op == OP_SUBMIT) begin
            if (free_slots.size() == 0) begin
               r.status = ST_FULL;
               n_rejected++;
            end else begin
               lv = prio;
               if (prio == LV_CRITICAL && levels[LV_CRITICAL].size() >= CRIT_SLOTS) begin
                  lv = LV_HIGH;
                  r.degraded = 1'b1;
                  n_degraded++;
               end
               // freed slots go to the front of the free list
               idx = free_slots.pop_front();
               slot_handle[idx] = hdl;
               slot_time[idx] = now;
               slot_dl[idx] = dl;
               levels[lv].push_back(idx);
               r.status = ST_ACCEPTED;
            end
         end else if (op == OP_DEQUEUE) begin
            if (levels[LV_CRITICAL].size() != 0) begin
               idx = levels[LV_CRITICAL].pop_front();
               r.handle = slot_handle[idx];
               r.level = LV_CRITICAL;
               r.status = ST_DISPATCH;
               free_slots.push_front(idx);
               exec_total++;
            end else begin
               // whole background promotion, then one-step escalation
               if (guard_ms != 0 && levels[0].size() != 0 && is_aged(0, now, guard_ms)) begin
                  while (levels[0].size() != 0) levels[1].push_back(levels[0].pop_front());
                  bump_total++;
               end
               if (escal_ms != 0) begin
                  while (levels[1].size() != 0 && is_aged(1, now, escal_ms))
                     levels[2].push_back(levels[1].pop_front());
                  while (levels[2].size() != 0 && levels[3].size() < CRIT_SLOTS &&
                         is_aged(2, now, escal_ms))
                     levels[3].push_back(levels[2].pop_front());
               end
               for (lv = 3; lv >= 0; lv--) begin
                  if (levels[lv].size() != 0) begin
                     idx = levels[lv].pop_front();
                     r.handle = slot_handle[idx];
                     r.level = 2'(lv);
                     if (slot_dl[idx] != 0 && now > slot_dl[idx]) begin
                        r.status = ST_EXPIRED;
                        n_expired++;
                     end else begin
                        r.status = ST_DISPATCH;
                     end
                     free_slots.push_front(idx);
                     exec_total++;
                     break;
                  end
               end
            end
         end else if (op == OP_FLUSH) begin
            clear_store();
            r.status = ST_ACCEPTED;
         end
         r.d_bg = 7'(levels[0].size());
         r.d_nm = 7'(levels[1].size());
         r.d_hi = 7'(levels[2].size());
         r.d_cr = 7'(levels[3].size());
         r.executed = exec_total;
         r.bumps = bump_total;
         pending.push_back(r);
      endfunction

      function void check_response(task_rsp_type got);
         task_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat %p", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch #%0d\n  expected %p\n  actual   %p",
                                       checked, want, got);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [1:0]  req_priority_req;
   logic [15:0] req_task_handle;
   logic [31:0] req_deadline_ms;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_handle;
   logic [1:0]  rsp_served_level;
   logic        rsp_degraded;
   logic [6:0]  rsp_depth_background;
   logic [6:0]  rsp_depth_normal;
   logic [6:0]  rsp_depth_high;
   logic [6:0]  rsp_depth_critical;
   logic [31:0] rsp_executed_count;
   logic [31:0] rsp_bump_count;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   aging_priority_task_queue #(.ENTRIES(DEPTH), .CRITICAL_SLOTS(CRIT_SLOTS)) dut (.*);

   task_queue_scoreboard sb;
   logic [31:0] clock_ms;
   bit          rx_idle_on;
   bit          long_hold;
   int          cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle cap
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("aging_priority_task_queue regression: fail");
            $finish;
         end
      end
   end

   // response side: check each accepted beat, stall in random bursts
   initial begin
      int gap;
      rsp_ready = 1'b0;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset)
            sb.check_response({rsp_status, rsp_out_handle, rsp_served_level, rsp_degraded,
                               rsp_depth_background, rsp_depth_normal, rsp_depth_high,
                               rsp_depth_critical, rsp_executed_count, rsp_bump_count});
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // valid stays up between back to back beats unless an idle gap is drawn; drain_all drops it
   task automatic send_req(logic [1:0] op, logic [1:0] prio, logic [15:0] hdl,
                           logic [31:0] dl, logic [31:0] now, bit idle);
      int gap;
      if (idle && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_priority_req <= prio;
      req_task_handle <= hdl;
      req_deadline_ms <= dl;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, prio, hdl, dl, now);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DEPTH + 40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_STARVATION) sb.guard_ms = val;
      else sb.escal_ms = val;
      @(posedge clock);
   endtask

   // one random item, mostly submits and dequeues with time moving forward
   task automatic random_req(bit idle);
      int pick;
      logic [1:0] op;
      logic [31:0] dl;
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 1500);
      if (pick < 52) op = OP_SUBMIT;
      else if (pick < 97) op = OP_DEQUEUE;
      else if (pick < 98) op = OP_FLUSH;
      else op = OP_NONE;
      case ($urandom_range(0, 3))
         0: dl = 32'd0;
         1: dl = clock_ms + $urandom_range(0, 3000);
         2: dl = $urandom;
         default: dl = clock_ms - $urandom_range(0, 100);
      endcase
      send_req(op, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), dl,
               ($urandom_range(0, 30) == 0) ? $urandom : clock_ms, idle);
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SUBMIT;
      req_priority_req = LV_BACKGROUND;
      req_task_handle = '0;
      req_deadline_ms = '0;
      req_now_ms = '0;
      csr_valid = 1'b0;
      csr_index = CSR_STARVATION;
      csr_data = '0;
      rx_idle_on = 1'b1;
      long_hold = 1'b0;
      clock_ms = 32'd100;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (DEPTH + 8) @(posedge clock);

      // directed: level order, critical degrade, expiry, empty, flush
      send_req(OP_DEQUEUE, LV_BACKGROUND, 16'h0000, 32'd0, 32'd0, 0);
      send_req(OP_SUBMIT, LV_BACKGROUND, 16'hffff, 32'hffffffff, 32'd0, 0);
      send_req(OP_SUBMIT, LV_NORMAL, 16'h0001, 32'd10, 32'd0, 0);
      send_req(OP_SUBMIT, LV_HIGH, 16'h0002, 32'd0, 32'd0, 0);
      for (int i = 0; i < CRIT_SLOTS + 2; i++)
         send_req(OP_SUBMIT, LV_CRITICAL, 16'(16'h0100 + i), 32'd0, 32'd0, 0);
      for (int i = 0; i < CRIT_SLOTS; i++)
         send_req(OP_DEQUEUE, LV_BACKGROUND, 16'h0, 32'd0, 32'hffffffff, 0);
      send_req(OP_DEQUEUE, LV_BACKGROUND, 16'h0, 32'd0, 32'd20, 0);
      send_req(OP_DEQUEUE, LV_BACKGROUND, 16'h0, 32'd0, 32'd9000, 0);
      send_req(OP_NONE, LV_CRITICAL, 16'hffff, 32'hffffffff, 32'hffffffff, 0);
      send_req(OP_FLUSH, LV_BACKGROUND, 16'h0, 32'd0, 32'd0, 0);
      drain_all();

      // fill the store past capacity with the response side held off
      long_hold = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         begin
            for (int i = 0; i < DEPTH + 3; i++)
               send_req(OP_SUBMIT, 2'(i % 4), 16'(i), 32'd0, 32'd500, 0);
            req_valid <= 1'b0;
         end
      join
      drain_all();
      send_req(OP_FLUSH, LV_BACKGROUND, 16'h0, 32'd0, 32'd0, 0);
      drain_all();

      // random phases across register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(CSR_STARVATION, 32'd0); write_csr(CSR_ESCALATION, 32'd0); end
            1: begin write_csr(CSR_STARVATION, 32'hffffffff);
                     write_csr(CSR_ESCALATION, 32'hffffffff); end
            2: begin write_csr(CSR_STARVATION, 32'd1); write_csr(CSR_ESCALATION, 32'd1); end
            3: begin write_csr(CSR_STARVATION, 32'd1000); write_csr(CSR_ESCALATION, 32'd5000); end
            default: begin write_csr(CSR_STARVATION, $urandom_range(1, 4000));
                           write_csr(CSR_ESCALATION, $urandom_range(1, 8000)); end
         endcase
         if (ph == 5) rx_idle_on = 1'b0;
         for (int n = 0; n < 280; n++) random_req(ph != 5);
         drain_all();
      end

      $display("covered %0d responses: %0d expired, %0d degraded, %0d rejected, %0d bumps",
               sb.checked, sb.n_expired, sb.n_degraded, sb.n_rejected, sb.bump_total);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("aging_priority_task_queue regression: pass");
      end else begin
         $display("%0d mismatches, %0d left pending", sb.errors, sb.pending.size());
         $display("aging_priority_task_queue regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
